FILE: rtl/sfta_pkg.sv
`timescale 1ns / 1ps
package sfta_pkg;

	localparam int unsigned MaxVerticesDefault = 2048;

	// commands
	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_VERT  = 2'd2;

	// register indexes
	localparam logic [2:0] REG_SCALE_X = 3'd0;
	localparam logic [2:0] REG_SCALE_Y = 3'd1;
	localparam logic [2:0] REG_SCALE_Z = 3'd2;
	localparam logic [2:0] REG_TRANS_X = 3'd3;
	localparam logic [2:0] REG_TRANS_Y = 3'd4;
	localparam logic [2:0] REG_TRANS_Z = 3'd5;
	localparam logic [2:0] REG_SNAP    = 3'd6;
	localparam logic [2:0] REG_MSCALE  = 3'd7;

	localparam logic [12:0] POS_MAX = 13'd8191;

	// one classified vertex handed from front to back
	typedef struct packed {
		logic        fan;
		logic        first;   // vertex position zero
		logic        emit;    // vertex position two or more
		logic        odd;     // strip parity of the vertex position
		logic        in_range;
		logic [31:0] s;
		logic [31:0] t;
	} vtx_job_t;

	typedef struct packed {
		logic [23:0] scale_x;
		logic [23:0] scale_y;
		logic [23:0] scale_z;
		logic [31:0] trans_x;
		logic [31:0] trans_y;
		logic [31:0] trans_z;
		logic [8:0]  snap;
		logic [15:0] mscale;
	} cfg_t;

	typedef struct packed {
		logic [31:0] s;
		logic [31:0] t;
		logic [31:0] x;
		logic [31:0] z;
		logic [31:0] y;
	} vtx_t;

endpackage

FILE: rtl/sfta_front.sv
`timescale 1ns / 1ps
module sfta_front #(
	parameter int unsigned MAX_VERTICES = sfta_pkg::MaxVerticesDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          command,
	input  logic [10:0]         vertex_index,
	input  logic [13:0]         prim_count,
	input  logic [31:0]         tex_s,
	input  logic [31:0]         tex_t,
	output logic                job_valid,
	input  logic                job_stall,
	output sfta_pkg::vtx_job_t  job,
	output logic [10:0]         job_index
);

	logic        fan_q;
	logic [12:0] pos_q;
	logic        take;

	// the front takes a transfer whenever the output slot is free or draining
	assign in_stall = job_valid & job_stall;
	assign take     = in_valid & ~in_stall;

	// primitive tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fan_q <= 1'b0;
			pos_q <= '0;
		end else if (take) begin
			if (command == sfta_pkg::CMD_START) begin
				fan_q <= (prim_count == '0) | prim_count[13];
				pos_q <= '0;
			end else if (command == sfta_pkg::CMD_VERT) begin
				pos_q <= (pos_q >= sfta_pkg::POS_MAX) ? sfta_pkg::POS_MAX - 13'd1
				                                      : pos_q + 13'd1;
			end
		end
	end

	// job slot, loads travel too so store writes stay in order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid <= 1'b0;
		end else if (!in_stall) begin
			job_valid <= take & ((command == sfta_pkg::CMD_VERT) |
			                     (command == sfta_pkg::CMD_LOAD));
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			job.fan      <= fan_q;
			job.first    <= (pos_q == '0);
			job.emit     <= (pos_q >= 13'd2);
			job.odd      <= pos_q[0] ^ 1'b0;
			job.in_range <= (32'(vertex_index) < MAX_VERTICES);
			job.s        <= tex_s;
			job.t        <= tex_t;
			job_index    <= vertex_index;
		end
	end

endmodule

FILE: rtl/sfta_xform.sv
`timescale 1ns / 1ps
// one component: scale, snap, translate, negate, model scale, round, saturate
module sfta_xform (
	input  logic        clk,
	input  logic        en,
	input  logic [7:0]  b,
	input  logic [23:0] scale,
	input  logic [8:0]  snap,
	input  logic [31:0] trans,
	input  logic [15:0] mscale,
	input  logic        negate,
	output logic [31:0] res
);

	logic [31:0] v_s1;
	logic [34:0] p_s2;
	logic [50:0] prod_s3;

	logic [31:0] v;
	logic [32:0] w;
	logic [15:0] wm;
	logic [31:0] vs;
	logic signed [34:0] p;
	logic        neg;
	logic [50:0] m;
	logic [39:0] r;

	always_comb begin
		v  = 32'(b) * 32'(scale);
		w  = 33'(v_s1) + (33'(snap) << 15);
		wm = w[31:16] & ~(16'(snap) - 16'd1);
		vs = (snap != '0) ? {wm, 16'd0} : v_s1;
		p  = signed'(35'(vs)) + 35'(signed'(trans));
		if (negate) p = -p;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s1 <= v;
		end
	end

	// stage 2 holds the signed sum, stage 3 the product
	always_ff @(posedge clk) begin
		p_s2    <= p;
		prod_s3 <= 51'(signed'(p_s2)) * signed'({35'd0, mscale});
	end

	always_comb begin
		neg = prod_s3[50];
		m   = neg ? (~prod_s3 + 51'd1) : prod_s3;
		r   = 40'((m + 51'd2048) >> 12);
		if (neg) res = (r > 40'h80000000) ? 32'h80000000 : 32'(~r + 40'd1);
		else     res = (r > 40'h7FFFFFFF) ? 32'h7FFFFFFF : r[31:0];
	end

endmodule

FILE: rtl/sfta_back.sv
`timescale 1ns / 1ps
module sfta_back #(
	parameter int unsigned MAX_VERTICES = sfta_pkg::MaxVerticesDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load_en,
	input  logic [10:0]        load_index,
	input  logic [23:0]        load_data,
	input  logic               job_valid,
	output logic               job_stall,
	input  sfta_pkg::vtx_job_t job,
	input  logic [10:0]        job_index,
	input  logic               job_is_vert,
	input  sfta_pkg::cfg_t     cfg,
	output logic               out_valid,
	input  logic               out_stall,
	output sfta_pkg::vtx_t     ovtx,
	output logic               last_of_triangle
);

	// the index port is 11 bits wide, so larger stores are addressed by those bits
	localparam int unsigned AW = (MAX_VERTICES > 2048) ? 11 : $clog2(MAX_VERTICES);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_X1   = 3'd2;
	localparam logic [2:0] ST_X2   = 3'd3;
	localparam logic [2:0] ST_X3   = 3'd4;
	localparam logic [2:0] ST_EMIT = 3'd5;

	logic [23:0] mem [MAX_VERTICES];
	logic [23:0] rd_q;
	logic        rng_q;
	logic [2:0]  state_q;
	logic [1:0]  cnt_q;
	sfta_pkg::vtx_job_t j_q;
	sfta_pkg::vtx_t first_q, a_q, b_q, cur_q;
	logic [23:0] bytes;
	logic [31:0] rx, ry, rz;
	logic        sel_en;

	// vertex store
	always_ff @(posedge clk) begin
		if (load_en && 32'(load_index) < MAX_VERTICES) begin
			mem[load_index[AW-1:0]] <= load_data;
		end
		rd_q <= mem[job_index[AW-1:0]];
	end

	assign bytes  = rng_q ? rd_q : 24'd0;
	assign sel_en = (state_q == ST_RD);

	sfta_xform u_x (.clk(clk), .en(sel_en), .b(bytes[7:0]), .scale(cfg.scale_x),
		.snap(cfg.snap), .trans(cfg.trans_x), .mscale(cfg.mscale), .negate(1'b0),
		.res(rx));
	sfta_xform u_y (.clk(clk), .en(sel_en), .b(bytes[15:8]), .scale(cfg.scale_y),
		.snap(cfg.snap), .trans(cfg.trans_y), .mscale(cfg.mscale), .negate(1'b1),
		.res(ry));
	sfta_xform u_z (.clk(clk), .en(sel_en), .b(bytes[23:16]), .scale(cfg.scale_z),
		.snap(cfg.snap), .trans(cfg.trans_z), .mscale(cfg.mscale), .negate(1'b0),
		.res(rz));

	assign job_stall = (state_q != ST_IDLE);

	// output selection per triangle slot
	always_comb begin
		last_of_triangle = (cnt_q == 2'd2);
		unique case (cnt_q)
			2'd0:    ovtx = j_q.fan ? first_q : a_q;
			2'd1:    ovtx = (j_q.fan || !j_q.odd) ? b_q : cur_q;
			default: ovtx = (j_q.fan || !j_q.odd) ? cur_q : b_q;
		endcase
	end

	// sequencer: read, three transform stages, then up to three transfers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			out_valid <= 1'b0;
			first_q   <= '0;
			a_q       <= '0;
			b_q       <= '0;
			cur_q     <= '0;
			j_q       <= '0;
			rng_q     <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid && job_is_vert) begin
						j_q     <= job;
						rng_q   <= job.in_range;
						state_q <= ST_RD;
					end
				end
				ST_RD: state_q <= ST_X1;
				ST_X1: state_q <= ST_X2;
				ST_X2: state_q <= ST_X3;
				ST_X3: begin
					cur_q <= '{s: j_q.s, t: j_q.t, x: rx, z: rz, y: ry};
					if (j_q.first) first_q <= '{s: j_q.s, t: j_q.t, x: rx, z: rz, y: ry};
					if (j_q.emit) begin
						cnt_q     <= '0;
						out_valid <= 1'b1;
						state_q   <= ST_EMIT;
					end else begin
						a_q     <= b_q;
						b_q     <= '{s: j_q.s, t: j_q.t, x: rx, z: rz, y: ry};
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (!out_stall) begin
						if (cnt_q == 2'd2) begin
							out_valid <= 1'b0;
							a_q       <= b_q;
							b_q       <= cur_q;
							state_q   <= ST_IDLE;
						end else begin
							cnt_q <= cnt_q + 2'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/strip_fan_triangle_assembly_core.sv
`timescale 1ns / 1ps
// strip and fan expansion to a triangle list with vertex dequantization
// input channel: in_valid/in_stall, one command per transfer (load vertex,
//   start primitive, primitive vertex); fields are separate ports
// output channel: out_valid/out_stall, one triangle-list vertex per transfer,
//   last_of_triangle marks the third vertex of a triangle
// configuration: cfg_we/cfg_index/cfg_data plain writes, only while idle
// path: a primitive vertex is registered in the job slot in front of the back
//   end, then passes a store read and three transform stages before its
//   triangle is shown; each triangle takes 3 output transfers
// sequencing: the back sequencer holds one vertex at a time and takes no new
//   job until it is done with that vertex, output stalls included;
//   starts stay in the front end, and loads are written once the back is idle
// the one-entry job slot between front and back lets the front take the
//   next command while the back is still emitting
// reset clears the primitive state, history vertices and registers to their
//   defaults; the vertex store is undefined until loaded
// a stalled receiver holds the current vertex; the back end then stops and
//   the front fills its slot before it raises in_stall
module strip_fan_triangle_assembly_core #(
	parameter int unsigned MAX_VERTICES = sfta_pkg::MaxVerticesDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [10:0] vertex_index,
	input  logic [7:0]  coord_x,
	input  logic [7:0]  coord_y,
	input  logic [7:0]  coord_z,
	input  logic signed [13:0] prim_count,
	input  logic [31:0] tex_s,
	input  logic [31:0] tex_t,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] out_s,
	output logic [31:0] out_t,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_z,
	output logic signed [31:0] pos_y,
	output logic        last_of_triangle
);

	sfta_pkg::cfg_t     cfg_q;
	sfta_pkg::vtx_job_t job;
	sfta_pkg::vtx_t     ovtx;
	logic               job_valid, job_stall, front_stall;
	logic [10:0]        job_index;
	logic               load_en, is_vert;
	logic [23:0]        load_q;
	logic               cmd_load_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale_x <= 24'd65536;
			cfg_q.scale_y <= 24'd65536;
			cfg_q.scale_z <= 24'd65536;
			cfg_q.trans_x <= '0;
			cfg_q.trans_y <= '0;
			cfg_q.trans_z <= '0;
			cfg_q.snap    <= '0;
			cfg_q.mscale  <= 16'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sfta_pkg::REG_SCALE_X: cfg_q.scale_x <= cfg_data[23:0];
				sfta_pkg::REG_SCALE_Y: cfg_q.scale_y <= cfg_data[23:0];
				sfta_pkg::REG_SCALE_Z: cfg_q.scale_z <= cfg_data[23:0];
				sfta_pkg::REG_TRANS_X: cfg_q.trans_x <= cfg_data;
				sfta_pkg::REG_TRANS_Y: cfg_q.trans_y <= cfg_data;
				sfta_pkg::REG_TRANS_Z: cfg_q.trans_z <= cfg_data;
				sfta_pkg::REG_SNAP:    cfg_q.snap    <= cfg_data[8:0];
				default:               cfg_q.mscale  <= cfg_data[15:0];
			endcase
		end
	end

	sfta_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(front_stall),
		.command(command), .vertex_index(vertex_index), .prim_count(prim_count),
		.tex_s(tex_s), .tex_t(tex_t), .job_valid(job_valid), .job_stall(job_stall),
		.job(job), .job_index(job_index));

	assign in_stall = front_stall;

	// load payload rides beside the job slot
	always_ff @(posedge clk) begin
		if (in_valid && !front_stall) begin
			load_q     <= {coord_z, coord_y, coord_x};
			cmd_load_q <= (command == sfta_pkg::CMD_LOAD);
		end
	end

	assign load_en = job_valid & ~job_stall & cmd_load_q;
	assign is_vert = ~cmd_load_q;

	sfta_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
		.clk(clk), .arst_n(arst_n), .load_en(load_en), .load_index(job_index),
		.load_data(load_q), .job_valid(job_valid), .job_stall(job_stall),
		.job(job), .job_index(job_index), .job_is_vert(is_vert), .cfg(cfg_q),
		.out_valid(out_valid), .out_stall(out_stall), .ovtx(ovtx),
		.last_of_triangle(last_of_triangle));

	assign out_s = ovtx.s;
	assign out_t = ovtx.t;
	assign pos_x = ovtx.x;
	assign pos_z = ovtx.z;
	assign pos_y = ovtx.y;

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
module testbench;

	localparam logic [1:0] CMD_NONE = 2'd3;

	typedef struct {
		logic [1:0]         cmd;
		logic [10:0]        idx;
		logic [7:0]         x, y, z;
		logic signed [13:0] cnt;
		logic [31:0]        s, t;
	} cmd_item_t;

	typedef struct {
		sfta_pkg::vtx_t v;
		logic last;
	} tri_vtx_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [1:0] command;
	logic [10:0] vertex_index;
	logic [7:0] coord_x, coord_y, coord_z;
	logic signed [13:0] prim_count;
	logic [31:0] tex_s, tex_t;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic [31:0] out_s, out_t;
	logic signed [31:0] pos_x, pos_z, pos_y;
	logic last_of_triangle;

	always #10 clk = ~clk;

	strip_fan_triangle_assembly_core u_top (.*);

	// pending commands and expected triangle-list vertices
	cmd_item_t cmd_queue[$];
	tri_vtx_t tri_expected[$];
	int errors = 0;
	int n_out = 0;
	bit calm = 1'b0;

	// assembler model state
	logic [23:0] scale_r[3];
	logic [31:0] trans_r[3];
	logic [8:0]  snap_r;
	logic [15:0] mscale_r;
	logic [23:0] vstore[2048];
	sfta_pkg::vtx_t first_v, hist_a, hist_b;
	int unsigned vpos;
	bit fan_on;

	// stimulus side bookkeeping of loaded entries
	int loaded_idx[$];
	bit loaded[2048];

	task automatic report(input string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm) return 0;
		if (r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// dequantize, snap, translate, negate, scale, round and saturate one component
	function automatic logic [31:0] dequant(input logic [7:0] b, input int c, input bit neg);
		longint v, w, p, prod, m, r;
		v = longint'(b) * longint'(scale_r[c]);
		if (snap_r != 0) begin
			w = (v + (longint'(snap_r) << 15)) >>> 16;
			w = w & ~(longint'(snap_r) - 1);
			v = w << 16;
		end
		p = v + longint'($signed(trans_r[c]));
		if (neg) p = -p;
		prod = p * longint'(mscale_r);
		m = (prod < 0) ? -prod : prod;
		r = (m + 2048) >>> 12;
		if (prod < 0) return (r > 64'h8000_0000) ? 32'h8000_0000 : 32'(-r);
		return (r > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(r);
	endfunction

	function automatic void push_tri(input sfta_pkg::vtx_t a, input sfta_pkg::vtx_t b,
			input sfta_pkg::vtx_t c);
		tri_expected.push_back('{a, 1'b0});
		tri_expected.push_back('{b, 1'b0});
		tri_expected.push_back('{c, 1'b1});
	endfunction

	// advance the assembler model by one accepted command
	function automatic void assemble(input cmd_item_t it);
		sfta_pkg::vtx_t v;
		logic [23:0] pk;
		case (it.cmd)
			sfta_pkg::CMD_LOAD: vstore[it.idx] = {it.z, it.y, it.x};
			sfta_pkg::CMD_START: begin
				fan_on = (it.cnt <= 0);
				vpos = 0;
			end
			sfta_pkg::CMD_VERT: begin
				pk = vstore[it.idx];
				v.s = it.s;
				v.t = it.t;
				v.x = dequant(pk[7:0], 0, 1'b0);
				v.z = dequant(pk[23:16], 2, 1'b0);
				v.y = dequant(pk[15:8], 1, 1'b1);
				if (vpos == 0) first_v = v;
				if (vpos >= 2) begin
					if (fan_on) push_tri(first_v, hist_b, v);
					else if (((vpos - 2) & 1) == 0) push_tri(hist_a, hist_b, v);
					else push_tri(hist_a, v, hist_b);
				end
				hist_a = hist_b;
				hist_b = v;
				vpos = (vpos >= 8191) ? 8190 : vpos + 1;
			end
			default: ;
		endcase
	endfunction

	// input driver
	int in_gap;
	cmd_item_t cur;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			command <= CMD_NONE;
			vertex_index <= '0;
			coord_x <= '0;
			coord_y <= '0;
			coord_z <= '0;
			prim_count <= '0;
			tex_s <= '0;
			tex_t <= '0;
			in_gap = 0;
		end else begin
			if (in_valid && !in_stall) assemble(cur);
			if (!in_valid || !in_stall) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (cmd_queue.size() > 0) begin
					cur = cmd_queue.pop_front();
					command <= cur.cmd;
					vertex_index <= cur.idx;
					coord_x <= cur.x;
					coord_y <= cur.y;
					coord_z <= cur.z;
					prim_count <= cur.cnt;
					tex_s <= cur.s;
					tex_t <= cur.t;
					in_valid <= 1'b1;
					in_gap = rand_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output stall pattern, with one long hold-off to back up the block
	int stall_left, hold_left;
	bit held;
	always @(posedge clk or negedge arst_n) begin
		int g;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
			hold_left = 0;
			held = 1'b0;
		end else if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (!held && n_out >= 40) begin
			held = 1'b1;
			hold_left = 400;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			g = rand_gap();
			out_stall <= (g != 0);
			stall_left = (g > 0) ? g - 1 : 0;
		end
	end

	// output monitor
	always @(posedge clk) begin
		tri_vtx_t e;
		if (arst_n && out_valid && !out_stall) begin
			n_out <= n_out + 1;
			if (tri_expected.size() == 0) begin
				report("output transfer with nothing expected");
			end else begin
				e = tri_expected.pop_front();
				if (out_s !== e.v.s) report($sformatf("out_s %h exp %h", out_s, e.v.s));
				if (out_t !== e.v.t) report($sformatf("out_t %h exp %h", out_t, e.v.t));
				if (pos_x !== e.v.x) report($sformatf("pos_x %h exp %h", pos_x, e.v.x));
				if (pos_z !== e.v.z) report($sformatf("pos_z %h exp %h", pos_z, e.v.z));
				if (pos_y !== e.v.y) report($sformatf("pos_y %h exp %h", pos_y, e.v.y));
				if (last_of_triangle !== e.last)
					report($sformatf("last_of_triangle %b exp %b", last_of_triangle, e.last));
			end
		end
	end

	function automatic void push_cmd(input logic [1:0] c, input logic [10:0] i,
			input logic [7:0] x, input logic [7:0] y, input logic [7:0] z,
			input logic signed [13:0] n, input logic [31:0] s, input logic [31:0] t);
		cmd_queue.push_back('{c, i, x, y, z, n, s, t});
	endfunction

	function automatic void push_load(input logic [10:0] i, input logic [7:0] x,
			input logic [7:0] y, input logic [7:0] z);
		push_cmd(sfta_pkg::CMD_LOAD, i, x, y, z, 14'($urandom), $urandom, $urandom);
		if (!loaded[i]) begin
			loaded[i] = 1'b1;
			loaded_idx.push_back(i);
		end
	endfunction

	function automatic void push_vert(input logic [10:0] i, input logic [31:0] s,
			input logic [31:0] t);
		push_cmd(sfta_pkg::CMD_VERT, i, 8'($urandom), 8'($urandom), 8'($urandom),
			14'($urandom), s, t);
	endfunction

	function automatic void push_start(input logic signed [13:0] n);
		push_cmd(sfta_pkg::CMD_START, 11'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom), n, $urandom, $urandom);
	endfunction

	function automatic logic [10:0] any_loaded();
		return 11'(loaded_idx[$urandom_range(0, loaded_idx.size() - 1)]);
	endfunction

	// mostly well-formed primitives with random content, some noise
	function automatic void random_cmds(input int n);
		int k, r;
		k = 0;
		while (k < n) begin
			r = $urandom_range(0, 9);
			if (r == 0) begin
				push_cmd(CMD_NONE, 11'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom), 14'($urandom), $urandom, $urandom);
				k++;
			end else if (r == 1) begin
				push_load(11'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
				k++;
			end else begin
				if (r != 2) begin
					push_start(14'($urandom_range(0, 8192)) - 14'sd4096);
					k++;
				end
				repeat ($urandom_range(1, 10)) begin
					push_vert(any_loaded(), $urandom, $urandom);
					k++;
				end
			end
		end
	endfunction

	task automatic drain();
		while (cmd_queue.size() > 0 || in_valid) @(posedge clk);
		while (tri_expected.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// write all registers back to back while the block is idle
	task automatic configure(input logic [23:0] sx, input logic [23:0] sy,
			input logic [23:0] sz, input logic [31:0] tx, input logic [31:0] ty,
			input logic [31:0] tz, input logic [8:0] sn, input logic [15:0] ms);
		logic [31:0] vals[8];
		logic [2:0] regs_idx[8];
		vals = '{32'(sx), 32'(sy), 32'(sz), tx, ty, tz, 32'(sn), 32'(ms)};
		regs_idx = '{sfta_pkg::REG_SCALE_X, sfta_pkg::REG_SCALE_Y, sfta_pkg::REG_SCALE_Z,
			sfta_pkg::REG_TRANS_X, sfta_pkg::REG_TRANS_Y, sfta_pkg::REG_TRANS_Z,
			sfta_pkg::REG_SNAP, sfta_pkg::REG_MSCALE};
		for (int i = 0; i < 8; i++) begin
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_index <= regs_idx[i];
			cfg_data <= vals[i];
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		scale_r = '{sx, sy, sz};
		trans_r = '{tx, ty, tz};
		snap_r = sn;
		mscale_r = ms;
	endtask

	initial begin
		scale_r = '{24'd65536, 24'd65536, 24'd65536};
		trans_r = '{32'd0, 32'd0, 32'd0};
		snap_r = '0;
		mscale_r = 16'd256;
		first_v = '0;
		hist_a = '0;
		hist_b = '0;
		vpos = 0;
		fan_on = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: vertices before any start run as a strip from reset
		push_load(11'd0, 8'd0, 8'd0, 8'd0);
		push_load(11'd2047, 8'd255, 8'd255, 8'd255);
		push_load(11'd1365, 8'h55, 8'hAA, 8'h0F);
		push_vert(11'd0, 32'h0, 32'hFFFF_FFFF);
		push_vert(11'd2047, 32'hFFFF_FFFF, 32'h0);
		push_vert(11'd1365, 32'h3F80_0000, 32'hBF00_0000);
		push_vert(11'd0, 32'h1234_5678, 32'h9ABC_DEF0);
		push_start(-14'sd4096);
		repeat (5) push_vert(any_loaded(), $urandom, $urandom);
		push_cmd(CMD_NONE, 11'd5, 8'd1, 8'd2, 8'd3, 14'sd1, 32'd1, 32'd2);
		push_start(14'sd4096);
		repeat (5) push_vert(any_loaded(), $urandom, $urandom);
		push_start(14'sd0);
		repeat (3) push_vert(any_loaded(), $urandom, $urandom);
		drain();

		// extremes high
		configure(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 9'd256, 16'hFFFF);
		random_cmds(40);
		drain();

		// extremes low, negative translate
		configure(24'd0, 24'd0, 24'd0, 32'h8000_0000, 32'h7FFF_FFFF,
			32'hFFFF_0000, 9'd0, 16'd1);
		random_cmds(30);
		drain();

		// random settings with a power of two grid, no idling
		calm = 1'b1;
		configure(24'($urandom), 24'($urandom), 24'($urandom), $urandom, $urandom,
			$urandom, 9'(1 << $urandom_range(0, 8)), 16'($urandom_range(1, 65535)));
		random_cmds(50);
		drain();
		calm = 1'b0;

		// non-power-of-two grid and zero model scale
		configure(24'($urandom), 24'($urandom), 24'($urandom), $urandom, $urandom,
			$urandom, 9'd100, 16'd0);
		random_cmds(30);
		drain();

		// odd grid, random scale
		configure(24'($urandom), 24'($urandom), 24'($urandom), $urandom, $urandom,
			$urandom, 9'd3, 16'($urandom_range(1, 65535)));
		random_cmds(40);
		drain();

		// longer strip with different scales per axis
		calm = 1'b1;
		configure(24'd65536, 24'd32768, 24'd131072, 32'd0, 32'h0001_0000,
			32'hFFFF_8000, 9'd0, 16'd256);
		push_start(14'sd7);
		repeat (16) push_vert(any_loaded(), $urandom, $urandom);
		drain();

		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// watchdog
	initial begin
		#40ms;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: sim.f
rtl/sfta_pkg.sv
rtl/sfta_front.sv
rtl/sfta_xform.sv
rtl/sfta_back.sv
rtl/strip_fan_triangle_assembly_core.sv
bench/testbench.sv
